[rtl/bst_pkg.sv]
// Shared constants, codes and inter-module structs of the buffer slot table.
package bst_pkg;

  // Table geometry.
  localparam int unsigned SLOT_COUNT       = 32;
  localparam int unsigned DISK_BLOCK_COUNT = 8192;
  localparam int unsigned AGE_BITS         = 16;

  localparam int unsigned SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned BLK_W      = (DISK_BLOCK_COUNT > 2) ? $clog2(DISK_BLOCK_COUNT) : 1;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned REQ_BLK_W  = 16;

  // Request operations; the unused code acts as a lookup.
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_ALLOCATE   = 2'd1,
    OP_MARK_DIRTY = 2'd2,
    OP_SPARE      = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OOB     = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  // Scan token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    logic [BLK_W-1:0]      blk;
    logic                  found;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [AGE_BITS-1:0]   best_age;
    logic [SLOT_IDX_W-1:0] best_idx;
    logic                  best_dirty;
    logic [BLK_W-1:0]      best_blk;
  } token_t;

  // Update broadcast to every cell at the end of a scan.
  typedef struct packed {
    logic                  valid;
    logic                  allocate;
    logic                  set_dirty;
    logic [SLOT_IDX_W-1:0] pick;
    logic [BLK_W-1:0]      blk;
  } commit_t;

endpackage

[rtl/bst_cell.sv]
// One slot of the table: its state plus one stage of the scan token chain.
module bst_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bst_pkg::SLOT_IDX_W-1:0] slot_id_i,
  input  bst_pkg::token_t                token_i,
  input  bst_pkg::commit_t               commit_i,
  output bst_pkg::token_t                token_o
);
  import bst_pkg::*;

  logic                occ_q, occ_d;
  logic                dirty_q, dirty_d;
  logic [BLK_W-1:0]    blk_q, blk_d;
  logic [AGE_BITS-1:0] age_q, age_d;
  logic [AGE_BITS-1:0] aged;
  logic                tok_valid_q;
  token_t              tok_d, tok_q;
  logic                mine;

  // Saturating increment of this slot's age.
  assign aged = (age_q == {AGE_BITS{1'b1}}) ? age_q : age_q + AGE_BITS'(1);

  // Fold this slot into the token: first hit, first free slot, oldest slot.
  always_comb begin
    tok_d = token_i;
    if (!token_i.found && occ_q && (blk_q == token_i.blk)) begin
      tok_d.found   = 1'b1;
      tok_d.hit_idx = slot_id_i;
    end
    if (!token_i.free_found && !occ_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = slot_id_i;
    end
    if (aged > token_i.best_age) begin
      tok_d.best_age   = aged;
      tok_d.best_idx   = slot_id_i;
      tok_d.best_dirty = dirty_q;
      tok_d.best_blk   = blk_q;
    end
  end

  // Apply the end-of-scan update: aging, refill of the chosen slot, dirty mark.
  assign mine = commit_i.valid && (commit_i.pick == slot_id_i);

  always_comb begin
    occ_d   = occ_q;
    dirty_d = dirty_q;
    blk_d   = blk_q;
    age_d   = age_q;
    if (commit_i.valid && commit_i.allocate && occ_q) begin
      age_d = aged;
    end
    if (mine && commit_i.allocate) begin
      occ_d   = 1'b1;
      dirty_d = 1'b0;
      blk_d   = commit_i.blk;
      age_d   = '0;
    end
    if (mine && commit_i.set_dirty) begin
      dirty_d = 1'b1;
    end
  end

  // Slot control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= 1'b0;
      dirty_q     <= 1'b0;
      age_q       <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      dirty_q     <= dirty_d;
      age_q       <= age_d;
      tok_valid_q <= token_i.valid;
    end
  end

  // Block number and token payload need no reset.
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    tok_q <= tok_d;
  end

  always_comb begin
    token_o       = tok_q;
    token_o.valid = tok_valid_q;
  end

endmodule

[rtl/bst_ctrl.sv]
// Request sequencer: injects the scan token, decides the outcome, drives results.
module bst_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bst_pkg::OP_W-1:0]       operation_i,
  input  logic signed [bst_pkg::REQ_BLK_W-1:0] block_number_i,
  input  bst_pkg::token_t                token_i,
  output bst_pkg::token_t                token_o,
  output bst_pkg::commit_t               commit_o,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [bst_pkg::STATUS_W-1:0]   status_o,
  output logic [bst_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic                           writeback_valid_o,
  output logic [bst_pkg::BLK_W-1:0]      writeback_block_o,
  output logic [bst_pkg::SLOT_IDX_W-1:0] writeback_slot_o
);
  import bst_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                state_q;
  logic [OP_W-1:0]       op_q;
  logic                  oob_q;
  logic                  accept;
  logic                  req_oob;
  logic                  scan_end;
  status_e               status_d;
  logic [SLOT_IDX_W-1:0] slot_d;
  logic                  wb_valid_d;
  logic [BLK_W-1:0]      wb_blk_d;
  logic [SLOT_IDX_W-1:0] wb_slot_d;
  logic                  done_q;
  status_e               status_q;
  logic [SLOT_IDX_W-1:0] slot_q;
  logic                  wb_valid_q;
  logic [BLK_W-1:0]      wb_blk_q;
  logic [SLOT_IDX_W-1:0] wb_slot_q;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign scan_end = token_i.valid && (state_q == ST_SCAN);

  // Negative numbers and numbers at or above the disk size are out of bound.
  assign req_oob = block_number_i[REQ_BLK_W-1] ||
                   ({1'b0, block_number_i[REQ_BLK_W-2:0]} >= REQ_BLK_W'(DISK_BLOCK_COUNT));

  // Fresh token entering the first cell.
  always_comb begin
    token_o       = '0;
    token_o.valid = accept;
    token_o.blk   = block_number_i[BLK_W-1:0];
  end

  // Outcome of the scan and the matching table update.
  always_comb begin
    status_d   = STATUS_OK;
    slot_d     = '0;
    wb_valid_d = 1'b0;
    wb_blk_d   = '0;
    wb_slot_d  = '0;
    commit_o   = '0;
    commit_o.blk = token_i.blk;
    if (oob_q) begin
      status_d = STATUS_OOB;
    end else if (op_q == OP_ALLOCATE) begin
      commit_o.valid    = scan_end;
      commit_o.allocate = 1'b1;
      if (token_i.free_found) begin
        slot_d = token_i.free_idx;
      end else begin
        slot_d = token_i.best_idx;
        if (token_i.best_dirty) begin
          wb_valid_d = 1'b1;
          wb_blk_d   = token_i.best_blk;
          wb_slot_d  = token_i.best_idx;
        end
      end
      commit_o.pick = slot_d;
    end else if (token_i.found) begin
      slot_d             = token_i.hit_idx;
      commit_o.valid     = scan_end && (op_q == OP_MARK_DIRTY);
      commit_o.set_dirty = 1'b1;
      commit_o.pick      = token_i.hit_idx;
    end else begin
      status_d = STATUS_MISSING;
    end
  end

  // Sequencer state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      oob_q <= req_oob;
    end
    if (scan_end) begin
      status_q   <= status_d;
      slot_q     <= slot_d;
      wb_valid_q <= wb_valid_d;
      wb_blk_q   <= wb_blk_d;
      wb_slot_q  <= wb_slot_d;
    end
  end

  assign busy_o            = (state_q == ST_SCAN);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign slot_index_o      = slot_q;
  assign writeback_valid_o = wb_valid_q;
  assign writeback_block_o = wb_blk_q;
  assign writeback_slot_o  = wb_slot_q;

endmodule

[rtl/buffer_slot_table_lru.sv]
// Top level of the buffer slot table with age-based replacement.
//
// A request (operation_i, block_number_i) is taken at a rising edge where
// start_i is high and busy_o is low. busy_o then stays high while a scan
// token walks the row of slot cells, one cell per cycle, gathering the first
// matching slot, the lowest free slot and the oldest slot. When it leaves the
// last cell the sequencer updates the table (aging, refill, dirty mark).
// The result appears on status_o, slot_index_o and the writeback ports for
// exactly one cycle with done_o high, registered once the token has left the
// last cell, and is taken at the edge that ends that cycle. busy_o is
// already low in that cycle, so the next request can be taken at that same
// edge. The scan time is set by the length of the cell chain.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// Reset empties every slot (free, clean, age zero) and drops any transaction
// in flight; no clearing pass is needed.
module buffer_slot_table_lru (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [bst_pkg::OP_W-1:0]       operation_i,
  input  logic signed [bst_pkg::REQ_BLK_W-1:0] block_number_i,
  output logic                           done_o,
  output logic [bst_pkg::STATUS_W-1:0]   status_o,
  output logic [bst_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic                           writeback_valid_o,
  output logic [bst_pkg::BLK_W-1:0]      writeback_block_o,
  output logic [bst_pkg::SLOT_IDX_W-1:0] writeback_slot_o
);
  import bst_pkg::*;

  token_t  chain [SLOT_COUNT+1];
  commit_t commit;

  // Sequencer at the head and tail of the chain.
  bst_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .operation_i       (operation_i),
    .block_number_i    (block_number_i),
    .token_i           (chain[SLOT_COUNT]),
    .token_o           (chain[0]),
    .commit_o          (commit),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_block_o (writeback_block_o),
    .writeback_slot_o  (writeback_slot_o)
  );

  // Row of slot cells, each passing the token to the next.
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    bst_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .slot_id_i (SLOT_IDX_W'(g)),
      .token_i   (chain[g]),
      .commit_i  (commit),
      .token_o   (chain[g+1])
    );
  end

  // A result strobe ends the transaction: the block is free in that cycle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted request holds the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not start a scan");

  // A strobe follows only a cycle in which the block was busy.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a scan");

  // A writeback is reported only with a successful transaction.
  a_wb_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && writeback_valid_o) |-> (status_o == STATUS_OK))
    else $error("writeback on a failed transaction");

  // A failed transaction names slot zero.
  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |-> (slot_index_o == '0))
    else $error("failed transaction with a slot index");

endmodule
